// File: src/mrf_pkg.sv
`default_nettype none
package mrf_pkg;

   localparam int MRF_QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_KIND     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLAVE_ADDRESS  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WRITE_MODE     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_REGISTER = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WORD_COUNT     = 3'd4;

   localparam logic [1:0] KIND_RTU_SINGLE = 2'd0;
   localparam logic [1:0] KIND_TCP_SINGLE = 2'd1;
   localparam logic [1:0] KIND_TCP_MULTI  = 2'd2;
   localparam logic [1:0] KIND_UNUSED     = 2'd3;

   localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
   localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;
   localparam logic [7:0] MBAP_SINGLE_LEN  = 8'h06;

   localparam logic [8:0] MULTI_LEN_BASE   = 9'd7;
   localparam logic [8:0] MULTI_DATA_START = 9'd13;
   localparam logic [3:0] MULTI_DATA_POS   = 4'd13;

   localparam logic [3:0] RTU_LAST_INDEX          = 4'd7;
   localparam logic [3:0] TCP_LAST_INDEX          = 4'd11;
   localparam logic [3:0] MULTI_HEADER_LAST_INDEX = 4'd14;
   localparam logic [3:0] MULTI_WORD_LAST_INDEX   = 4'd1;
   localparam logic [3:0] CRC_FIRST_INDEX         = 4'd6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  slave;
      logic        write_fc;
      logic [15:0] start;
      logic [15:0] value;
      logic        header;
      logic [6:0]  count;
      logic [8:0]  base;
      logic        last;
   } desc_type;

endpackage
`default_nettype wire

// File: src/mrf_front.sv
`default_nettype none
module mrf_front
   import mrf_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [15:0]                req_register_value,
   output logic                            push_valid,
   output desc_type                        push_data,
   input  wire logic                       push_ready
);

   logic [1:0]  frame_kind_ff;
   logic [7:0]  slave_address_ff;
   logic        write_mode_ff;
   logic [15:0] start_register_ff;
   logic [6:0]  word_count_ff;
   logic [6:0]  words_sent_ff;
   logic [6:0]  words_sent_in;

   logic        accept;
   logic [6:0]  count;
   logic [7:0]  done;
   logic        frame_done;

   always_comb begin
      count      = (word_count_ff == 7'd0) ? 7'd1 : word_count_ff;
      done       = {1'b0, words_sent_ff} + 8'd1;
      frame_done = done >= {1'b0, count};
      accept     = req_valid && push_ready;
      req_ready  = push_ready;
      push_valid = req_valid && (frame_kind_ff != KIND_UNUSED);

      push_data.kind     = frame_kind_ff;
      push_data.slave    = slave_address_ff;
      push_data.write_fc = write_mode_ff;
      push_data.start    = start_register_ff;
      push_data.value    = req_register_value;
      push_data.count    = count;
      push_data.header   = 1'b0;
      push_data.base     = 9'd0;
      push_data.last     = 1'b1;
      if (frame_kind_ff == KIND_TCP_MULTI) begin
         push_data.header = (words_sent_ff == 7'd0);
         push_data.base   = (words_sent_ff == 7'd0) ? 9'd0
                          : {1'b0, words_sent_ff, 1'b0} + MULTI_DATA_START;
         push_data.last   = frame_done;
      end

      words_sent_in = words_sent_ff;
      if (accept) begin
         case (frame_kind_ff)
            KIND_RTU_SINGLE: words_sent_in = 7'd0;
            KIND_TCP_SINGLE: words_sent_in = 7'd0;
            KIND_TCP_MULTI:  words_sent_in = frame_done ? 7'd0 : done[6:0];
            default:         words_sent_in = words_sent_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_kind_ff     <= KIND_RTU_SINGLE;
         slave_address_ff  <= 8'd1;
         write_mode_ff     <= 1'b0;
         start_register_ff <= 16'd0;
         word_count_ff     <= 7'd1;
         words_sent_ff     <= 7'd0;
      end else begin
         words_sent_ff <= words_sent_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FRAME_KIND:     frame_kind_ff     <= csr_write_data[1:0];
               CSR_SLAVE_ADDRESS:  slave_address_ff  <= csr_write_data[7:0];
               CSR_WRITE_MODE:     write_mode_ff     <= csr_write_data[0];
               CSR_START_REGISTER: start_register_ff <= csr_write_data[15:0];
               CSR_WORD_COUNT:     word_count_ff     <= csr_write_data[6:0];
               default:            ;
            endcase
         end
      end
   end

   a_single_clears_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (frame_kind_ff == KIND_RTU_SINGLE || frame_kind_ff == KIND_TCP_SINGLE))
      |=> (words_sent_ff == 7'd0))
      else $error("single frame left a multiple frame open");

endmodule
`default_nettype wire

// File: src/mrf_queue.sv
`default_nettype none
module mrf_queue
   import mrf_pkg::*;
#(
   parameter int DEPTH = MRF_QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  desc_type      push_data,
   output logic          push_ready,
   output logic          pop_valid,
   output desc_type      pop_data,
   input  wire logic     pop
);

   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   desc_type                 entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]     wr_ptr_ff;
   logic [PTR_WIDTH-1:0]     rd_ptr_ff;
   logic [COUNT_WIDTH-1:0]   count_ff;
   logic                     do_push;
   logic                     do_pop;

   always_comb begin
      push_ready = count_ff != COUNT_WIDTH'(DEPTH);
      pop_valid  = count_ff != '0;
      pop_data   = entry_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop && pop_valid;
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_pop_only_when_filled: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: src/mrf_back.sv
`default_nettype none
module mrf_back
   import mrf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        pop_valid,
   input  desc_type         pop_data,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_frame_byte,
   output logic [8:0]       rsp_byte_offset,
   output logic             rsp_last_byte
);

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   logic        rsp_valid_ff;
   logic [7:0]  byte_ff;
   logic [8:0]  offset_ff;
   logic        last_ff;
   logic [3:0]  index_ff;
   logic [3:0]  index_in;
   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   logic        emit;
   logic        final_byte;
   logic [3:0]  last_index;
   logic [3:0]  pos;
   logic [7:0]  fc;
   logic [8:0]  multi_len;
   logic [7:0]  next_byte;

   always_comb begin
      emit = pop_valid && (!rsp_valid_ff || rsp_ready);
      fc   = pop_data.write_fc ? FC_WRITE_SINGLE : FC_READ_HOLDING;
      multi_len = {1'b0, pop_data.count, 1'b0} + MULTI_LEN_BASE;
      pos  = pop_data.header ? index_ff : index_ff + MULTI_DATA_POS;

      case (pop_data.kind)
         KIND_RTU_SINGLE: last_index = RTU_LAST_INDEX;
         KIND_TCP_SINGLE: last_index = TCP_LAST_INDEX;
         default: last_index = pop_data.header ? MULTI_HEADER_LAST_INDEX
                                               : MULTI_WORD_LAST_INDEX;
      endcase
      final_byte = index_ff == last_index;

      next_byte = 8'd0;
      case (pop_data.kind)
         KIND_RTU_SINGLE: begin
            case (index_ff)
               4'd0:    next_byte = pop_data.slave;
               4'd1:    next_byte = fc;
               4'd2:    next_byte = pop_data.start[15:8];
               4'd3:    next_byte = pop_data.start[7:0];
               4'd4:    next_byte = pop_data.value[15:8];
               4'd5:    next_byte = pop_data.value[7:0];
               4'd6:    next_byte = crc_ff[7:0];
               4'd7:    next_byte = crc_ff[15:8];
               default: next_byte = 8'd0;
            endcase
         end
         KIND_TCP_SINGLE: begin
            case (index_ff)
               4'd5:    next_byte = MBAP_SINGLE_LEN;
               4'd6:    next_byte = pop_data.slave;
               4'd7:    next_byte = fc;
               4'd8:    next_byte = pop_data.start[15:8];
               4'd9:    next_byte = pop_data.start[7:0];
               4'd10:   next_byte = pop_data.value[15:8];
               4'd11:   next_byte = pop_data.value[7:0];
               default: next_byte = 8'd0;
            endcase
         end
         default: begin
            case (pos)
               4'd4:    next_byte = {7'd0, multi_len[8]};
               4'd5:    next_byte = multi_len[7:0];
               4'd6:    next_byte = pop_data.slave;
               4'd7:    next_byte = FC_WRITE_MULTI;
               4'd8:    next_byte = pop_data.start[15:8];
               4'd9:    next_byte = pop_data.start[7:0];
               4'd11:   next_byte = {1'b0, pop_data.count};
               4'd12:   next_byte = {pop_data.count, 1'b0};
               4'd13:   next_byte = pop_data.value[15:8];
               4'd14:   next_byte = pop_data.value[7:0];
               default: next_byte = 8'd0;
            endcase
         end
      endcase

      pop      = emit && final_byte;
      index_in = index_ff;
      crc_in   = crc_ff;
      if (emit) begin
         if (final_byte) begin
            index_in = 4'd0;
            crc_in   = CRC_INIT;
         end else begin
            index_in = index_ff + 4'd1;
            if (index_ff < CRC_FIRST_INDEX) begin
               crc_in = crc_byte(crc_ff, next_byte);
            end
         end
      end

      rsp_valid       = rsp_valid_ff;
      rsp_frame_byte  = byte_ff;
      rsp_byte_offset = offset_ff;
      rsp_last_byte   = last_ff;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff   <= next_byte;
         offset_ff <= pop_data.base + {5'd0, index_ff};
         last_ff   <= final_byte && pop_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         index_ff     <= 4'd0;
         crc_ff       <= CRC_INIT;
      end else begin
         index_ff <= index_in;
         crc_ff   <= crc_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_index_idle_at_zero: assert property (@(posedge clock) disable iff (reset)
      !pop_valid |-> (index_ff == 4'd0))
      else $error("byte index advanced without a pending item");

   a_crc_fresh_at_start: assert property (@(posedge clock) disable iff (reset)
      (index_ff == 4'd0) |-> (crc_ff == CRC_INIT))
      else $error("crc not restarted at frame start");

endmodule
`default_nettype wire

// File: src/modbus_request_framer_unit.sv
`default_nettype none
// Modbus master request framer. Each accepted item (one register value) is
// turned into request frame bytes, one byte per cycle on the rsp_ channel
// while rsp_ready is high: an RTU single request is 8 bytes, a TCP single
// request 12, the first word of a TCP write-multiple frame 15 and each later
// word 2. The byte sequencer in the back end sets these counts and folds
// each of the first six RTU bytes into the CRC. Configuration is read
// when an item is accepted; items of frame kind 3 are accepted and dropped.
// A queue of QUEUE_DEPTH items sits between the front end and the byte
// sequencer, so req_ready stays high while earlier frames are still sent and
// a stalled rsp_ side only blocks the input once the queue is full.
module modbus_request_framer_unit
   import mrf_pkg::*;
#(
   parameter int QUEUE_DEPTH = MRF_QUEUE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [15:0]                req_register_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [7:0]                      rsp_frame_byte,
   output logic [8:0]                      rsp_byte_offset,
   output logic                            rsp_last_byte
);

   logic     push_valid;
   logic     push_ready;
   desc_type push_data;
   logic     pop_valid;
   logic     pop;
   desc_type pop_data;

   mrf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_register_value (req_register_value),
      .push_valid         (push_valid),
      .push_data          (push_data),
      .push_ready         (push_ready)
   );

   mrf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop)
   );

   mrf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule
`default_nettype wire

// File: dv/modbus_request_framer_unit_tb.sv
module modbus_request_framer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrf_pkg::*;

   localparam int RANDOM_ITEMS   = 350;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic [8:0] offset;
      logic       last;
   } frame_byte_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [15:0]                req_register_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [7:0]                 rsp_frame_byte;
   logic [8:0]                 rsp_byte_offset;
   logic                       rsp_last_byte;

   logic [1:0]  cfg_frame_kind = KIND_RTU_SINGLE;
   logic [7:0]  cfg_slave = 8'd1;
   logic        cfg_write_mode = 1'b0;
   logic [15:0] cfg_start = 16'd0;
   logic [6:0]  cfg_word_count = 7'd1;
   logic [6:0]  open_words = 7'd0;

   logic [15:0]    pending_words[$];
   frame_byte_type expected_bytes[$];
   idle_mode_type  idle_mode = IDLE_NONE;
   logic           req_fire = 1'b0;
   int             items_waiting = 0;
   int             items_counted = 0;
   int             mismatch_count = 0;
   int             stall_cycles = 0;

   modbus_request_framer_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_register_value (req_register_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_last_byte      (rsp_last_byte)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   task automatic predict_frame(input logic [15:0] value);
      logic [7:0]     fb [0:14];
      logic [7:0]     fc;
      logic [15:0]    crc;
      logic [8:0]     len;
      logic [8:0]     base;
      logic [6:0]     cnt;
      logic           closes;
      frame_byte_type b;
      int             n;
      fc = cfg_write_mode ? FC_WRITE_SINGLE : FC_READ_HOLDING;
      cnt = (cfg_word_count == 7'd0) ? 7'd1 : cfg_word_count;
      n = 0;
      base = 9'd0;
      closes = 1'b1;
      case (cfg_frame_kind)
         KIND_RTU_SINGLE: begin
            fb[0] = cfg_slave;
            fb[1] = fc;
            fb[2] = cfg_start[15:8];
            fb[3] = cfg_start[7:0];
            fb[4] = value[15:8];
            fb[5] = value[7:0];
            crc = 16'hFFFF;
            for (int k = 0; k < 6; k++) crc = crc16_byte(crc, fb[k]);
            fb[6] = crc[7:0];
            fb[7] = crc[15:8];
            n = 8;
            open_words = 7'd0;
         end
         KIND_TCP_SINGLE: begin
            for (int k = 0; k < 5; k++) fb[k] = 8'd0;
            fb[5] = 8'd6;
            fb[6] = cfg_slave;
            fb[7] = fc;
            fb[8] = cfg_start[15:8];
            fb[9] = cfg_start[7:0];
            fb[10] = value[15:8];
            fb[11] = value[7:0];
            n = 12;
            open_words = 7'd0;
         end
         KIND_TCP_MULTI: begin
            if (open_words == 7'd0) begin
               len = 9'd7 + {1'b0, cnt, 1'b0};
               for (int k = 0; k < 4; k++) fb[k] = 8'd0;
               fb[4] = {7'd0, len[8]};
               fb[5] = len[7:0];
               fb[6] = cfg_slave;
               fb[7] = 8'd16;
               fb[8] = cfg_start[15:8];
               fb[9] = cfg_start[7:0];
               fb[10] = 8'd0;
               fb[11] = {1'b0, cnt};
               fb[12] = {cnt, 1'b0};
               n = 13;
               base = 9'd0;
            end else begin
               base = 9'd13 + {1'b0, open_words, 1'b0};
            end
            fb[n] = value[15:8];
            fb[n + 1] = value[7:0];
            n += 2;
            closes = (int'(open_words) + 1 >= int'(cnt));
            open_words = closes ? 7'd0 : open_words + 7'd1;
         end
         default: begin
         end
      endcase
      for (int k = 0; k < n; k++) begin
         b.data = fb[k];
         b.offset = base + 9'(k);
         b.last = (k == n - 1) && closes;
         expected_bytes.push_back(b);
      end
   endtask

   function automatic logic [15:0] random_field(input int width);
      logic [15:0] top;
      top = 16'((32'd1 << width) - 1);
      case ($urandom_range(7))
         0: return 16'd0;
         1: return top;
         default: return 16'($urandom) & top;
      endcase
   endfunction

   function automatic logic [15:0] pad_register(input logic [15:0] value, input int width);
      if ($urandom_range(3) == 0) begin
         return value | 16'($urandom << width);
      end
      return value;
   endfunction

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [15:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      case (index)
         CSR_FRAME_KIND:     cfg_frame_kind = data[1:0];
         CSR_SLAVE_ADDRESS:  cfg_slave = data[7:0];
         CSR_WRITE_MODE:     cfg_write_mode = data[0];
         CSR_START_REGISTER: cfg_start = data;
         CSR_WORD_COUNT:     cfg_word_count = data[6:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_item(input logic [15:0] value);
      pending_words.push_back(value);
      items_waiting++;
      if (cfg_frame_kind != KIND_UNUSED) items_counted++;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      while (items_waiting != 0 || expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      logic hold_off;
      logic stall;
      hold_off = (idle_mode == IDLE_SENDER && $urandom_range(99) < 54) ||
                 (idle_mode == IDLE_BOTH && $urandom_range(99) < 9);
      stall = (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 54) ||
              (idle_mode == IDLE_BOTH && $urandom_range(99) < 9);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_words.size() != 0 && !hold_off) begin
            req_valid <= 1'b1;
            req_register_value <= pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !stall;
   end

   always @(posedge clock) begin
      frame_byte_type want;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_frame(req_register_value);
            items_waiting--;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: unexpected frame byte %02h offset %0d last %0b",
                           $realtime, rsp_frame_byte, rsp_byte_offset, rsp_last_byte);
               end
               mismatch_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_frame_byte !== want.data || rsp_byte_offset !== want.offset ||
                   rsp_last_byte !== want.last) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: frame byte mismatch: expected %02h/%0d/%0b got %02h/%0d/%0b",
                              $realtime, want.data, want.offset, want.last,
                              rsp_frame_byte, rsp_byte_offset, rsp_last_byte);
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("modbus_request_framer_unit regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int          phase;
      int          r;
      int          burst;
      int          remaining;
      int          cnt_eff;
      int          target;
      logic [1:0]  kind;
      logic [15:0] count_value;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // reset configuration: RTU read request to station 1
      queue_item(16'h0000);
      queue_item(16'hFFFF);
      wait_quiet();
      for (int k = int'(CSR_WORD_COUNT) + 1; k < 2 ** CSR_INDEX_WIDTH; k++) begin
         write_register(k[CSR_INDEX_WIDTH-1:0], 16'($urandom));
      end
      queue_item(16'h8000);
      wait_quiet();

      write_register(CSR_WRITE_MODE, 16'hFFFF);
      write_register(CSR_SLAVE_ADDRESS, 16'h00FF);
      write_register(CSR_START_REGISTER, 16'hFFFF);
      queue_item(16'h1234);
      queue_item(16'hA5A5);
      wait_quiet();

      idle_mode = IDLE_SENDER;
      write_register(CSR_FRAME_KIND, {14'd0, KIND_TCP_SINGLE});
      write_register(CSR_SLAVE_ADDRESS, 16'hFF00);
      write_register(CSR_START_REGISTER, 16'h0000);
      write_register(CSR_WRITE_MODE, 16'h0000);
      queue_item(16'hFFFF);
      wait_quiet();
      write_register(CSR_WRITE_MODE, 16'h0001);
      queue_item(16'h0001);
      wait_quiet();

      idle_mode = IDLE_BOTH;
      write_register(CSR_FRAME_KIND, 16'hFFFE);
      write_register(CSR_WORD_COUNT, 16'd3);
      write_register(CSR_START_REGISTER, 16'h8001);
      queue_item(16'h0102);
      queue_item(16'hFEDC);
      queue_item(16'h7FFF);
      wait_quiet();

      // zero count acts as one word
      write_register(CSR_WORD_COUNT, 16'd0);
      queue_item(16'h5A5A);
      wait_quiet();

      // count above the protocol limit, then lowered mid frame
      idle_mode = IDLE_RECEIVER;
      write_register(CSR_WORD_COUNT, 16'd127);
      queue_item(16'h1111);
      queue_item(16'h2222);
      wait_quiet();
      write_register(CSR_WORD_COUNT, 16'd2);
      queue_item(16'h3333);
      wait_quiet();

      // unused kind mid frame, resume, then abandon with a single request
      write_register(CSR_WORD_COUNT, 16'd5);
      queue_item(16'hAAAA);
      queue_item(16'h5555);
      wait_quiet();
      write_register(CSR_FRAME_KIND, {14'd0, KIND_UNUSED});
      queue_item(16'hDEAD);
      wait_quiet();
      write_register(CSR_FRAME_KIND, {14'd0, KIND_TCP_MULTI});
      queue_item(16'hBEEF);
      wait_quiet();
      write_register(CSR_FRAME_KIND, {14'd0, KIND_RTU_SINGLE});
      queue_item(16'hC0DE);
      wait_quiet();
      write_register(CSR_FRAME_KIND, {14'd0, KIND_TCP_MULTI});
      write_register(CSR_WRITE_MODE, 16'h0001);
      write_register(CSR_WORD_COUNT, 16'd1);
      queue_item(16'h0000);
      wait_quiet();

      target = items_counted + RANDOM_ITEMS;
      phase = 0;
      while (items_counted < target) begin
         idle_mode = idle_mode_type'(phase % 4);
         r = $urandom_range(99);
         if (r < 15) kind = KIND_RTU_SINGLE;
         else if (r < 30) kind = KIND_TCP_SINGLE;
         else if (r < 92) kind = KIND_TCP_MULTI;
         else kind = KIND_UNUSED;
         write_register(CSR_FRAME_KIND, pad_register({14'd0, kind}, 2));
         if ($urandom_range(1)) write_register(CSR_SLAVE_ADDRESS, pad_register(random_field(8), 8));
         if ($urandom_range(1)) write_register(CSR_WRITE_MODE, pad_register(random_field(1), 1));
         if ($urandom_range(1)) write_register(CSR_START_REGISTER, random_field(16));
         if ($urandom_range(1)) begin
            r = $urandom_range(99);
            if (r < 7) count_value = 16'd0;
            else if (r < 10) count_value = 16'd127;
            else if (r < 13) count_value = 16'd123;
            else if (r < 23) count_value = 16'd1;
            else count_value = 16'($urandom_range(2, 8));
            write_register(CSR_WORD_COUNT, pad_register(count_value, 7));
         end
         if (cfg_frame_kind == KIND_TCP_MULTI) begin
            cnt_eff = (cfg_word_count == 7'd0) ? 1 : int'(cfg_word_count);
            remaining = (int'(open_words) < cnt_eff) ? cnt_eff - int'(open_words) : 1;
            if ($urandom_range(3) == 0) burst = $urandom_range(1, remaining);
            else if (cnt_eff <= 8 && $urandom_range(1)) burst = remaining + cnt_eff;
            else burst = remaining;
         end else if (cfg_frame_kind == KIND_UNUSED) begin
            burst = $urandom_range(1, 3);
         end else begin
            burst = $urandom_range(3, 12);
         end
         if (cfg_frame_kind != KIND_UNUSED && burst > target - items_counted) begin
            burst = target - items_counted;
         end
         repeat (burst) queue_item(random_field(16));
         wait_quiet();
         phase++;
      end

      if (mismatch_count == 0) begin
         $display("modbus_request_framer_unit regression: pass");
      end else begin
         $display("modbus_request_framer_unit regression: fail");
      end
      $finish;
   end

endmodule

// File: modbus_request_framer_unit.f
src/mrf_pkg.sv
src/mrf_front.sv
src/mrf_queue.sv
src/mrf_back.sv
src/modbus_request_framer_unit.sv
dv/modbus_request_framer_unit_tb.sv
